[src/env_sensor_compensation_macros.svh]
// Assertion macros shared by the compensation block's RTL.
// No dependencies; included by the top level.
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ESC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked after the given delay, outside reset.
`define ESC_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## (dly) (cons)) \
		else $error(msg);

`endif

[src/esc_pkg.sv]
// Package for the environmental sensor compensation block: payload and
// calibration types, pipeline constants and signed shift-divide helpers.
// No dependencies.
`default_nettype none

package esc_pkg;

	localparam int unsigned ESC_FRONT_STAGES = 12;
	localparam int unsigned ESC_DIV_BITS     = 64;
	localparam int unsigned ESC_BACK_STAGES  = 12;
	localparam int unsigned ESC_LATENCY      =
		ESC_FRONT_STAGES + ESC_DIV_BITS + ESC_BACK_STAGES;

	localparam logic signed [20:0] TEMP_MIN    = -21'sd4000;
	localparam logic signed [20:0] TEMP_MAX    = 21'sd8500;
	localparam logic [23:0]        PRESS_MIN   = 24'd3000000;
	localparam logic [23:0]        PRESS_MAX   = 24'd11000000;
	localparam logic [16:0]        HUM_MAX     = 17'd102400;
	localparam logic signed [31:0] HUM_VAR_MAX = 32'sd419430400;
	localparam logic signed [32:0] FINE_P_OFS  = 33'sd128000;
	localparam logic signed [31:0] FINE_H_OFS  = 32'sd76800;
	localparam logic signed [63:0] P_BIAS      = 64'sd140737488355328;
	localparam logic [20:0]        P_FULL      = 21'd1048576;

	typedef enum logic [2:0] {
		REG_RAW_MODE,
		REG_CAL_TEMP,
		REG_CAL_PRESS_A,
		REG_CAL_PRESS_B,
		REG_CAL_HUM_A,
		REG_CAL_HUM_B
	} esc_reg_t;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} esc_sample_t;

	typedef struct packed {
		logic signed [20:0] temperature;
		logic [23:0]        pressure;
		logic [16:0]        humidity;
	} esc_result_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
		logic [7:0]         h1;
		logic signed [15:0] h2;
		logic [7:0]         h3;
		logic signed [15:0] h4;
		logic signed [15:0] h5;
		logic signed [7:0]  h6;
	} esc_cal_t;

	// Fields that ride alongside the pressure division
	typedef struct packed {
		logic signed [20:0] temperature;
		logic signed [31:0] c;
		logic [15:0]        adc_h;
		logic [19:0]        adc_p;
		logic               qneg;
		logic               dzero;
	} esc_side_t;

	typedef struct packed {
		logic [63:0] nmag;
		logic [30:0] dmag;
		esc_side_t   side;
	} esc_div_in_t;

	typedef struct packed {
		logic [63:0] qmag;
		esc_side_t   side;
	} esc_div_out_t;

	// Signed divide by 2**k, truncating toward zero
	function automatic logic signed [31:0] sdiv32(input logic signed [31:0] v,
			input int unsigned k);
		logic [31:0] bias;
		bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
		return $signed(v + bias) >>> k;
	endfunction

	function automatic logic signed [63:0] sdiv64(input logic signed [63:0] v,
			input int unsigned k);
		logic [63:0] bias;
		bias = v[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
		return $signed(v + bias) >>> k;
	endfunction

endpackage

`default_nettype wire

[src/esc_mul64.sv]
// Two-stage multiplier giving the low 64 bits of a 64x64 product.
// Depends on nothing; used by the back end of the pressure path.
`default_nettype none

module esc_mul64 (
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] pp0_s1;
	logic [31:0] pp1_s1;
	logic [31:0] pp2_s1;
	logic [63:0] p_s2;

	// cross terms only matter in their low 32 bits
	always_ff @(posedge clk) begin
		pp0_s1 <= a[31:0] * b[31:0];
		pp1_s1 <= a[31:0] * b[63:32];
		pp2_s1 <= a[63:32] * b[31:0];
		p_s2   <= pp0_s1 + {pp1_s1 + pp2_s1, 32'd0};
	end

	assign p = p_s2;
endmodule

`default_nettype wire

[src/esc_front.sv]
// Front end: temperature compensation, fine temperature and the pressure
// terms up to the divider operands. Depends on esc_pkg.
`default_nettype none

module esc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  esc_pkg::esc_sample_t sample,
	input  esc_pkg::esc_cal_t    cal,
	input  logic                 raw_mode,
	output logic                 out_vld,
	output esc_pkg::esc_div_in_t div_in
);
	import esc_pkg::*;

	logic [ESC_FRONT_STAGES:1] vld_s;

	esc_sample_t smp_s [1:5];
	esc_side_t   side_s [6:12];

	logic signed [18:0] ta_s1;
	logic signed [16:0] tb_s1;
	logic signed [31:0] pa_s2, pb_s2;
	logic signed [31:0] a_s3, pc_s3;
	logic signed [31:0] fine_s4;
	logic signed [31:0] t5_s5, c_s5;
	logic signed [32:0] x_s5;
	logic signed [63:0] xx_s6;
	logic signed [48:0] xp5_s6, xp2_s6, xp5_s7, xp2_s7;
	logic signed [63:0] y1_s7, xa1_s7;
	logic signed [63:0] y_s8, xa_s8;
	logic signed [63:0] xs_s9, num0_s9;
	logic signed [63:0] xm_s10, num_s10;
	logic signed [30:0] xb_s11;
	logic signed [63:0] num_s11;
	logic [63:0]        nmag_s12;
	logic [30:0]        dmag_s12;

	logic signed [34:0] pa_full;
	logic signed [33:0] pb_full;
	logic signed [31:0] pb2;
	logic signed [47:0] pc_full;
	logic signed [31:0] tq;
	logic signed [20:0] temp_c;
	logic signed [65:0] xx_full;
	logic signed [48:0] xp5_full, xp2_full;
	logic signed [79:0] y1_full, xa1_full;
	logic [20:0]        v0;
	logic signed [80:0] xm_full;
	logic signed [63:0] xbw;
	esc_side_t          side6_d, side12_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[ESC_FRONT_STAGES-1:1], in_vld};
		end
	end

	always_comb begin
		pa_full  = ta_s1 * $signed(cal.t2);
		pb_full  = tb_s1 * tb_s1;
		pb2      = sdiv32(pb_s2, 12);
		pc_full  = pb2 * $signed(cal.t3);
		tq       = sdiv32(t5_s5, 8);
		if (raw_mode) begin
			temp_c = $signed({1'b0, smp_s[5].raw_temperature});
		end else if (tq < TEMP_MIN) begin
			temp_c = TEMP_MIN;
		end else if (tq > TEMP_MAX) begin
			temp_c = TEMP_MAX;
		end else begin
			temp_c = tq[20:0];
		end
		xx_full  = x_s5 * x_s5;
		xp5_full = x_s5 * $signed(cal.p5);
		xp2_full = x_s5 * $signed(cal.p2);
		y1_full  = xx_s6 * $signed(cal.p6);
		xa1_full = xx_s6 * $signed(cal.p3);
		v0       = P_FULL - {1'b0, side_s[8].adc_p};
		xm_full  = xs_s9 * $signed({1'b0, cal.p1});
		xbw      = sdiv64(xm_s10, 33);

		side6_d             = '0;
		side6_d.temperature = temp_c;
		side6_d.c           = c_s5;
		side6_d.adc_h       = smp_s[5].raw_humidity;
		side6_d.adc_p       = smp_s[5].raw_pressure;

		side12_d       = side_s[11];
		side12_d.qneg  = num_s11[63] ^ xb_s11[30];
		side12_d.dzero = (xb_s11 == '0);
	end

	always_ff @(posedge clk) begin
		// temperature
		smp_s[1] <= sample;
		ta_s1    <= $signed({2'b00, sample.raw_temperature[19:3]}) -
		            $signed({2'b00, cal.t1, 1'b0});
		tb_s1    <= $signed({1'b0, sample.raw_temperature[19:4]}) -
		            $signed({1'b0, cal.t1});
		for (int k = 2; k <= 5; k++) begin
			smp_s[k] <= smp_s[k-1];
		end
		pa_s2   <= pa_full[31:0];
		pb_s2   <= pb_full[31:0];
		a_s3    <= sdiv32(pa_s2, 11);
		pc_s3   <= pc_full[31:0];
		fine_s4 <= a_s3 + sdiv32(pc_s3, 14);
		t5_s5   <= fine_s4 * 32'sd5 + 32'sd128;
		x_s5    <= $signed({fine_s4[31], fine_s4}) - FINE_P_OFS;
		c_s5    <= fine_s4 - FINE_H_OFS;

		// pressure terms
		side_s[6] <= side6_d;
		xx_s6     <= xx_full[63:0];
		xp5_s6    <= xp5_full;
		xp2_s6    <= xp2_full;
		y1_s7     <= y1_full[63:0];
		xa1_s7    <= xa1_full[63:0];
		xp5_s7    <= xp5_s6;
		xp2_s7    <= xp2_s6;
		y_s8      <= y1_s7 + (64'(xp5_s7) <<< 17) + (64'($signed(cal.p4)) <<< 35);
		xa_s8     <= sdiv64(xa1_s7, 8) + (64'(xp2_s7) <<< 12);
		xs_s9     <= xa_s8 + P_BIAS;
		num0_s9   <= $signed({43'd0, v0} << 31) - y_s8;
		xm_s10    <= xm_full[63:0];
		num_s10   <= num0_s9 * 64'sd3125;
		xb_s11    <= xbw[30:0];
		num_s11   <= num_s10;
		for (int k = 7; k <= 11; k++) begin
			side_s[k] <= side_s[k-1];
		end

		// divider operands as magnitudes, sign kept aside
		nmag_s12   <= num_s11[63] ? (64'd0 - num_s11) : num_s11;
		dmag_s12   <= xb_s11[30] ? (31'd0 - xb_s11) : xb_s11;
		side_s[12] <= side12_d;
	end

	assign out_vld     = vld_s[ESC_FRONT_STAGES];
	assign div_in.nmag = nmag_s12;
	assign div_in.dmag = dmag_s12;
	assign div_in.side = side_s[12];
endmodule

`default_nettype wire

[src/esc_div.sv]
// Pipelined restoring divider for the pressure quotient, one quotient bit
// per stage, carrying side fields along. Depends on esc_pkg.
`default_nettype none

module esc_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  esc_pkg::esc_div_in_t  div_in,
	output logic                  out_vld,
	output esc_pkg::esc_div_out_t div_out
);
	import esc_pkg::*;

	logic [ESC_DIV_BITS:1] vld_s;
	logic [30:0]           rem_s  [1:ESC_DIV_BITS];
	logic [63:0]           nq_s   [1:ESC_DIV_BITS];
	logic [30:0]           dv_s   [1:ESC_DIV_BITS];
	esc_side_t             side_s [1:ESC_DIV_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[ESC_DIV_BITS-1:1], in_vld};
		end
	end

	for (genvar i = 1; i <= ESC_DIV_BITS; i++) begin : g_stage
		logic [30:0] rem_in;
		logic [63:0] nq_in;
		logic [30:0] dv_in;
		esc_side_t   side_in;
		logic [31:0] trial;
		logic        ge;

		if (i == 1) begin : g_first
			assign rem_in  = '0;
			assign nq_in   = div_in.nmag;
			assign dv_in   = div_in.dmag;
			assign side_in = div_in.side;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign nq_in   = nq_s[i-1];
			assign dv_in   = dv_s[i-1];
			assign side_in = side_s[i-1];
		end

		// nq holds the unused dividend bits above, quotient bits below
		assign trial = {rem_in, nq_in[63]};
		assign ge    = trial >= {1'b0, dv_in};

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? 31'(trial - {1'b0, dv_in}) : trial[30:0];
			nq_s[i]   <= {nq_in[62:0], ge};
			dv_s[i]   <= dv_in;
			side_s[i] <= side_in;
		end
	end

	assign out_vld      = vld_s[ESC_DIV_BITS];
	assign div_out.qmag = nq_s[ESC_DIV_BITS];
	assign div_out.side = side_s[ESC_DIV_BITS];
endmodule

`default_nettype wire

[src/esc_back.sv]
// Back end: pressure correction after the division, the humidity path
// and the result register. Depends on esc_pkg and esc_mul64.
`default_nettype none

module esc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  esc_pkg::esc_div_out_t div_out,
	input  esc_pkg::esc_cal_t     cal,
	input  logic                  raw_mode,
	output logic                  done,
	output esc_pkg::esc_result_t  result
);
	import esc_pkg::*;

	logic [ESC_BACK_STAGES:1] vld_s;
	esc_side_t                side_s [1:11];

	// pressure
	logic signed [63:0] q_s1, q_s2, q_s3, q_s4, q_s5, q_s6;
	logic signed [50:0] s_s2, s_s3;
	logic signed [63:0] n1_s2, n_s3, n_s4, n_s5, n_s6;
	logic signed [63:0] m1_s3, m_s6, sum_s7, v_s8, w_s9, q2_s10;
	logic [23:0]        press_s11;
	// humidity
	logic signed [31:0] ha0_s1, hb0_s1, hd0_s1, hx_s1, hy_s1;
	logic signed [31:0] e1_s2, e1_s3, e1_s4, e1_s5, e1_s6;
	logic signed [31:0] hx_s2, hy_s2, hd1_s3, d_s4, ha2_s5, a2_s6;
	logic signed [31:0] hb2_s7, hb2_s8, hb2_s9, hb2_s10, hb2_s11;
	logic signed [31:0] hs_s8, dd_s9, d2_s10, dh_s11;
	esc_result_t        result_s12;

	logic signed [47:0] hd0_full;
	logic signed [39:0] hx_full;
	logic signed [40:0] hy_full;
	logic signed [63:0] s_d;
	logic signed [79:0] n1_full;
	logic signed [66:0] m1_full;
	logic [63:0]        m2;
	logic [31:0]        p32;
	logic [23:0]        press_c;
	logic signed [31:0] e_d;
	logic [16:0]        hum_c;

	esc_mul64 u_mul (
		.clk (clk),
		.a   (m1_s3),
		.b   ({{13{s_s3[50]}}, s_s3}),
		.p   (m2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[ESC_BACK_STAGES-1:1], in_vld};
		end
	end

	always_comb begin
		hd0_full = $signed(cal.h5) * div_out.side.c;
		hx_full  = div_out.side.c * $signed(cal.h6);
		hy_full  = div_out.side.c * $signed({1'b0, cal.h3});
		s_d      = sdiv64(q_s1, 13);
		n1_full  = $signed(cal.p8) * q_s1;
		m1_full  = $signed(cal.p9) * s_s2;
		p32      = q2_s10[31:0];
		if (side_s[10].dzero || p32 < {8'd0, PRESS_MIN}) begin
			press_c = PRESS_MIN;
		end else if (p32 > {8'd0, PRESS_MAX}) begin
			press_c = PRESS_MAX;
		end else begin
			press_c = p32[23:0];
		end
		e_d = hb2_s11 - sdiv32(dh_s11, 4);
		if (e_d < 0) begin
			hum_c = '0;
		end else if (e_d > HUM_VAR_MAX) begin
			hum_c = HUM_MAX;
		end else begin
			hum_c = e_d[28:12];
		end
	end

	always_ff @(posedge clk) begin
		side_s[1] <= div_out.side;
		for (int k = 2; k <= 11; k++) begin
			side_s[k] <= side_s[k-1];
		end

		// pressure, after the quotient
		q_s1   <= div_out.side.qneg ? $signed(64'd0 - div_out.qmag) : $signed(div_out.qmag);
		s_s2   <= s_d[50:0];
		n1_s2  <= n1_full[63:0];
		q_s2   <= q_s1;
		m1_s3  <= m1_full[63:0];
		n_s3   <= sdiv64(n1_s2, 19);
		q_s3   <= q_s2;
		s_s3   <= s_s2;
		q_s4   <= q_s3;
		n_s4   <= n_s3;
		q_s5   <= q_s4;
		n_s5   <= n_s4;
		m_s6   <= sdiv64($signed(m2), 25);
		q_s6   <= q_s5;
		n_s6   <= n_s5;
		sum_s7 <= q_s6 + m_s6 + n_s6;
		v_s8   <= sdiv64(sum_s7, 8) + (64'($signed(cal.p7)) <<< 4);
		w_s9   <= sdiv64(v_s8, 1) * 64'sd100;
		q2_s10 <= sdiv64(w_s9, 7);
		press_s11 <= press_c;

		// humidity
		ha0_s1  <= $signed({2'b00, div_out.side.adc_h, 14'd0});
		hb0_s1  <= $signed({cal.h4[11:0], 20'd0});
		hd0_s1  <= hd0_full[31:0];
		hx_s1   <= hx_full[31:0];
		hy_s1   <= hy_full[31:0];
		e1_s2   <= sdiv32(ha0_s1 - hb0_s1 - hd0_s1 + 32'sd16384, 15);
		hx_s2   <= sdiv32(hx_s1, 10);
		hy_s2   <= sdiv32(hy_s1, 11);
		hd1_s3  <= hx_s2 * (hy_s2 + 32'sd32768);
		e1_s3   <= e1_s2;
		d_s4    <= sdiv32(hd1_s3, 10) + 32'sd2097152;
		e1_s4   <= e1_s3;
		ha2_s5  <= d_s4 * $signed(cal.h2);
		e1_s5   <= e1_s4;
		a2_s6   <= sdiv32(ha2_s5 + 32'sd8192, 14);
		e1_s6   <= e1_s5;
		hb2_s7  <= e1_s6 * a2_s6;
		hs_s8   <= sdiv32(hb2_s7, 15);
		hb2_s8  <= hb2_s7;
		dd_s9   <= hs_s8 * hs_s8;
		hb2_s9  <= hb2_s8;
		d2_s10  <= sdiv32(dd_s9, 7);
		hb2_s10 <= hb2_s9;
		dh_s11  <= d2_s10 * $signed({24'd0, cal.h1});
		hb2_s11 <= hb2_s10;

		// result register; raw temperature was folded in up front
		result_s12.temperature <= side_s[11].temperature;
		if (raw_mode) begin
			result_s12.pressure <= {4'd0, side_s[11].adc_p};
			result_s12.humidity <= {1'b0, side_s[11].adc_h};
		end else begin
			result_s12.pressure <= press_s11;
			result_s12.humidity <= hum_c;
		end
	end

	assign done   = vld_s[ESC_BACK_STAGES];
	assign result = result_s12;
endmodule

`default_nettype wire

[src/env_sensor_compensation.sv]
// Top level of the environmental sensor compensation block: configuration
// registers and the front end, divider and back end pipeline.
// Depends on esc_pkg, esc_front, esc_div, esc_back and the macro header.
//
// Takes one raw pressure/temperature/humidity transaction per clock
// (start; busy is never raised) and returns one result transaction per
// input, in order, through 12 front stages, 64 divider stages and 12
// back stages. done is high for one cycle with the result; there is
// no back-pressure, so the receiver must take it then. The pipeline
// length is set by the pressure division, a 64-bit signed quotient built
// one bit per pipeline stage. Temperature is in 0.01 C clamped to
// -4000..8500, pressure in 0.01 Pa clamped to 3000000..11000000 (a zero
// divisor gives 3000000), humidity in Q7.10 %RH up to 102400. With
// raw_mode set the readings pass straight through. Calibration and mode
// registers are written over the cfg channel (always ready) and must
// only change while no transaction is in flight.
`default_nettype none
`include "env_sensor_compensation_macros.svh"

module env_sensor_compensation (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  esc_pkg::esc_sample_t sample,
	output logic                 done,
	output esc_pkg::esc_result_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data
);
	import esc_pkg::*;

	logic        raw_mode_q;
	logic [47:0] cal_temp_q;
	logic [63:0] cal_press_a_q;
	logic [63:0] cal_press_b_q;
	logic [55:0] cal_hum_a_q;
	logic [31:0] cal_hum_b_q;

	esc_cal_t     cal;
	logic         front_vld;
	esc_div_in_t  div_in;
	logic         div_vld;
	esc_div_out_t div_out;

	// fully pipelined, no stall anywhere
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q    <= 1'b0;
			cal_temp_q    <= '0;
			cal_press_a_q <= '0;
			cal_press_b_q <= '0;
			cal_hum_a_q   <= '0;
			cal_hum_b_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (esc_reg_t'(cfg_index))
				REG_RAW_MODE:    raw_mode_q    <= cfg_data[0];
				REG_CAL_TEMP:    cal_temp_q    <= cfg_data[47:0];
				REG_CAL_PRESS_A: cal_press_a_q <= cfg_data;
				REG_CAL_PRESS_B: cal_press_b_q <= cfg_data;
				REG_CAL_HUM_A:   cal_hum_a_q   <= cfg_data[55:0];
				REG_CAL_HUM_B:   cal_hum_b_q   <= cfg_data[31:0];
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	// unpack calibration words into named coefficients
	always_comb begin
		cal.t1 = cal_temp_q[15:0];
		cal.t2 = cal_temp_q[31:16];
		cal.t3 = cal_temp_q[47:32];
		cal.p1 = cal_press_a_q[15:0];
		cal.p2 = cal_press_a_q[31:16];
		cal.p3 = cal_press_a_q[47:32];
		cal.p4 = cal_press_a_q[63:48];
		cal.p5 = cal_press_b_q[15:0];
		cal.p6 = cal_press_b_q[31:16];
		cal.p7 = cal_press_b_q[47:32];
		cal.p8 = cal_press_b_q[63:48];
		cal.p9 = cal_hum_a_q[15:0];
		cal.h1 = cal_hum_a_q[23:16];
		cal.h2 = cal_hum_a_q[39:24];
		cal.h3 = cal_hum_a_q[47:40];
		cal.h6 = cal_hum_a_q[55:48];
		cal.h4 = cal_hum_b_q[15:0];
		cal.h5 = cal_hum_b_q[31:16];
	end

	// temperature, fine temperature and divider operands
	esc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.sample   (sample),
		.cal      (cal),
		.raw_mode (raw_mode_q),
		.out_vld  (front_vld),
		.div_in   (div_in)
	);

	// pressure quotient
	esc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (front_vld),
		.div_in  (div_in),
		.out_vld (div_vld),
		.div_out (div_out)
	);

	// pressure tail, humidity and the output register
	esc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (div_vld),
		.div_out  (div_out),
		.cal      (cal),
		.raw_mode (raw_mode_q),
		.done     (done),
		.result   (result)
	);

	`ESC_ASSERT_DLY(a_done_after_accept, clk, arst_n, start && !busy, ESC_LATENCY, done, "accepted transaction gave no result at the expected cycle")
	`ESC_ASSERT_IMP(a_temp_range, clk, arst_n, done && !raw_mode_q, result.temperature >= TEMP_MIN && result.temperature <= TEMP_MAX, "temperature outside clamp range")
	`ESC_ASSERT_IMP(a_press_range, clk, arst_n, done && !raw_mode_q, result.pressure >= PRESS_MIN && result.pressure <= PRESS_MAX, "pressure outside clamp range")
	`ESC_ASSERT_IMP(a_hum_range, clk, arst_n, done && !raw_mode_q, result.humidity <= HUM_MAX, "humidity above clamp")
endmodule

`default_nettype wire
